// ----- rtl/sbe_pkg.sv -----
`timescale 1ns / 1ps

package sbe_pkg;

    // Default geometry of the basis.
    localparam int NUM_INNER_DEF = 6;
    localparam int ORDER_DEF     = 3;

    // Datapath widths, sized for the largest supported order and knot count.
    localparam int KNOT_W = 16;
    localparam int MV_W   = 40;
    localparam int ACC_W  = 64;
    localparam int DEN_W  = 19;
    localparam int MUL_W  = 19;
    localparam int MOUT_W = 24;
    localparam int IVAL_W = 17;
    localparam int IDX_W  = 5;
    localparam int LVL_W  = 3;
    localparam int CNT_W  = 7;

    // Reciprocal scaling for the fixed division of the I value by the order.
    localparam int I_SH = 22;
    localparam int I_RW = 22;

    localparam logic [IVAL_W-1:0] I_ONE = 17'h10000;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_LOWER = 3'd0;
    localparam logic [2:0] REG_UPPER = 3'd1;
    localparam logic [2:0] REG_KNOT1 = 3'd2;
    localparam logic [2:0] REG_KNOT2 = 3'd3;
    localparam logic [2:0] REG_KNOT3 = 3'd4;
    localparam logic [2:0] REG_KNOT4 = 3'd5;
    localparam logic [2:0] REG_KNOT5 = 3'd6;
    localparam logic [2:0] REG_KNOT6 = 3'd7;

    // Operation broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL,
        OP_SUMI,
        OP_SUM,
        OP_BIAS,
        OP_DIV,
        OP_STORE
    } op_t;

    // Which pass of the evaluation is running.
    typedef enum logic [1:0] {
        PH_BASE,
        PH_REC,
        PH_INT
    } phase_t;

    typedef struct packed {
        op_t              op;
        phase_t           phase;
        logic [LVL_W-1:0] lvl;
        logic [IDX_W-1:0] jint;
        logic             save;
    } cmd_t;

endpackage

// ----- rtl/sbe_cell.sv -----
`timescale 1ns / 1ps

module sbe_cell #(
    parameter int IDX   = 0,
    parameter int NKNOT = 14,
    parameter int MORD  = 4
) (
    input  logic                                         aclk,
    input  sbe_pkg::cmd_t                                cmd,
    input  logic [sbe_pkg::KNOT_W-1:0]                   sample,
    input  logic [NKNOT-1:0][sbe_pkg::KNOT_W-1:0]        knots,
    input  logic [sbe_pkg::MV_W-1:0]                     nb_mv,
    input  logic [sbe_pkg::ACC_W-1:0]                    nb_acc,
    output logic [sbe_pkg::MV_W-1:0]                     mv,
    output logic [sbe_pkg::ACC_W-1:0]                    acc,
    output logic [sbe_pkg::MOUT_W-1:0]                   mo,
    output logic [sbe_pkg::IVAL_W-1:0]                   iv
);
    import sbe_pkg::*;

    localparam int IP_W = MUL_W + I_RW;
    localparam logic [I_RW-1:0] I_RECIP =
        I_RW'(((64'd1 << I_SH) + 64'(MORD) - 64'd1) / 64'(MORD));

    logic [MV_W-1:0]   mv_reg, mv_next;
    logic [MOUT_W-1:0] mo_reg, mo_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [ACC_W-1:0]  w_reg, w_next;
    logic [MUL_W-1:0]  da_reg, da_next;
    logic [MUL_W-1:0]  db_reg, db_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic              ok_reg, ok_next;

    logic [KNOT_W-1:0] t_lo, t_hi, d1, d2, span;
    logic              has_hi, pos;
    logic [DEN_W:0]    trial;
    logic [MV_W-1:0]   mv_cap;
    logic [MV_W-1:0]   mv_new;
    logic [MUL_W-1:0]  iq0;
    logic [IP_W-1:0]   iprod;
    logic [IVAL_W-1:0] iv_q;

    // Knots bounding this cell's support at the current level.
    always_comb begin
        t_lo   = knots[IDX];
        t_hi   = '0;
        has_hi = 1'b0;
        for (int k = 0; k < NKNOT; k++) begin
            if (k == IDX + int'(cmd.lvl)) begin
                t_hi   = knots[k];
                has_hi = 1'b1;
            end
        end
        d1   = (sample > t_lo) ? sample - t_lo : '0;
        d2   = (t_hi > sample) ? t_hi - sample : '0;
        span = t_hi - t_lo;
        pos  = has_hi && (t_hi > t_lo);
    end

    // Step of the shared sequence: load, shift-add multiply, suffix sum, bias, divide, store.
    always_comb begin
        mv_next  = mv_reg;
        mo_next  = mo_reg;
        acc_next = acc_reg;
        w_next   = w_reg;
        da_next  = da_reg;
        db_next  = db_reg;
        den_next = den_reg;
        rem_next = rem_reg;
        ok_next  = ok_reg;
        trial    = {rem_reg, acc_reg[ACC_W-1]};
        mv_cap   = (|acc_reg[ACC_W-1:MV_W]) ? {MV_W{1'b1}} : acc_reg[MV_W-1:0];
        mv_new   = ok_reg ? mv_cap : '0;
        case (cmd.op)
            OP_LOAD: begin
                rem_next = '0;
                case (cmd.phase)
                    PH_BASE: begin
                        ok_next  = has_hi && (t_lo <= sample) && (sample < t_hi);
                        acc_next = ACC_W'(64'h1_0000_0000);
                        den_next = DEN_W'(span);
                    end
                    PH_REC: begin
                        ok_next  = pos;
                        acc_next = '0;
                        da_next  = MUL_W'(cmd.lvl) * MUL_W'(d1);
                        db_next  = MUL_W'(cmd.lvl) * MUL_W'(d2);
                        den_next = DEN_W'(cmd.lvl - LVL_W'(1)) * DEN_W'(span);
                    end
                    default: begin
                        ok_next  = pos && (IDX <= int'(cmd.jint));
                        acc_next = '0;
                        da_next  = MUL_W'(span);
                        db_next  = '0;
                    end
                endcase
            end
            OP_MUL: begin
                acc_next = (acc_reg << 1)
                         + (da_reg[MUL_W-1] ? ACC_W'(mv_reg) : '0)
                         + (db_reg[MUL_W-1] ? ACC_W'(nb_mv) : '0);
                da_next  = da_reg << 1;
                db_next  = db_reg << 1;
            end
            OP_SUMI: begin
                w_next   = ok_reg ? acc_reg : '0;
                acc_next = ok_reg ? acc_reg : '0;
            end
            OP_SUM: begin
                acc_next = w_reg + nb_acc;
            end
            OP_BIAS: begin
                acc_next = acc_reg + (ACC_W'(MORD) << 15);
            end
            OP_DIV: begin
                if (trial >= {1'b0, den_reg}) begin
                    rem_next = DEN_W'(trial - {1'b0, den_reg});
                    acc_next = {acc_reg[ACC_W-2:0], 1'b1};
                end else begin
                    rem_next = trial[DEN_W-1:0];
                    acc_next = {acc_reg[ACC_W-2:0], 1'b0};
                end
            end
            OP_STORE: begin
                if (cmd.phase != PH_INT) begin
                    mv_next = mv_new;
                    if (cmd.save) begin
                        mo_next = (|mv_new[MV_W-1:MOUT_W]) ? {MOUT_W{1'b1}}
                                                           : mv_new[MOUT_W-1:0];
                    end
                end
            end
            default: ;
        endcase
    end

    // I value from the biased sum: drop 16 fraction bits, then divide by the
    // order through a reciprocal multiply; sums of a full order or more clamp to one.
    always_comb begin
        iq0   = acc_reg[16 +: MUL_W];
        iprod = IP_W'(iq0) * IP_W'(I_RECIP);
        if (acc_reg >= (ACC_W'(MORD) << 32)) begin
            iv_q = I_ONE;
        end else begin
            iv_q = {1'b0, iprod[I_SH +: IVAL_W-1]};
        end
    end

    always_ff @(posedge aclk) begin
        mv_reg  <= mv_next;
        mo_reg  <= mo_next;
        acc_reg <= acc_next;
        w_reg   <= w_next;
        da_reg  <= da_next;
        db_reg  <= db_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        ok_reg  <= ok_next;
    end

    assign mv  = mv_reg;
    assign acc = acc_reg;
    assign mo  = mo_reg;
    assign iv  = iv_q;

endmodule

// ----- rtl/spline_basis_evaluator_top.sv -----
`timescale 1ns / 1ps
// One sample is taken at a time; its NUM_INNER+ORDER result words follow, one a cycle while
// m_ready is high. Each cell works through a 64-step bit-serial divider and a 19-step
// shift-add multiplier. A new sample is taken the cycle after the last word is delivered,
// so a sample is not accepted while the previous one is still being evaluated or emitted.
// Reset (aresetn, synchronous, active low) returns control to idle and loads knot defaults.
module spline_basis_evaluator_top #(
    parameter int NUM_INNER = sbe_pkg::NUM_INNER_DEF,
    parameter int ORDER     = sbe_pkg::ORDER_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [4:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sbe_pkg::KNOT_W-1:0]    s_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [3:0]                    m_basis_index,
    output logic [sbe_pkg::MOUT_W-1:0]    m_m_value,
    output logic [sbe_pkg::IVAL_W-1:0]    m_i_value,
    output logic                          m_last
);
    import sbe_pkg::*;

    localparam int MORD   = ORDER + 1;
    localparam int NKNOT  = NUM_INNER + 2 * MORD;
    localparam int NCELL  = NKNOT - 1;
    localparam int NBASIS = NUM_INNER + ORDER;
    localparam int NSRCH  = NUM_INNER + MORD;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_SUMI,
        ST_SUM,
        ST_BIAS,
        ST_DIV,
        ST_STORE,
        ST_EMIT
    } state_t;

    state_t            state_reg;
    logic [KNOT_W-1:0] lower_reg, upper_reg;
    logic [KNOT_W-1:0] inner_reg [6];
    logic [KNOT_W-1:0] x_reg;
    logic [IDX_W-1:0]  jint_reg;
    logic              found_reg, top_reg;
    logic [3:0]        lvl_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [3:0]        b_reg;
    logic              m_valid_reg, m_last_reg;
    logic [3:0]        m_index_reg;
    logic [MOUT_W-1:0] m_mval_reg;
    logic [IVAL_W-1:0] m_ival_reg;

    logic [NKNOT-1:0][KNOT_W-1:0] knots;
    logic [IDX_W-1:0]  jint_srch;
    logic              found_srch;
    cmd_t              cmd;
    logic              wr_en;
    logic [3:0]        b_sel;
    logic [MOUT_W-1:0] mo_sel;
    logic [IVAL_W-1:0] iv_sel, ival_sel;

    logic [MV_W-1:0]   mv_arr  [NCELL];
    logic [ACC_W-1:0]  acc_arr [NCELL];
    logic [MOUT_W-1:0] mo_arr  [NCELL];
    logic [IVAL_W-1:0] iv_arr  [NCELL];

    // Configuration port.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lower_reg    <= 16'd0;
            upper_reg    <= 16'd65535;
            inner_reg[0] <= 16'd9362;
            inner_reg[1] <= 16'd18724;
            inner_reg[2] <= 16'd28086;
            inner_reg[3] <= 16'd37449;
            inner_reg[4] <= 16'd46811;
            inner_reg[5] <= 16'd56173;
        end else if (wr_en) begin
            case (paddr[4:2])
                REG_LOWER: lower_reg    <= pwdata[KNOT_W-1:0];
                REG_UPPER: upper_reg    <= pwdata[KNOT_W-1:0];
                REG_KNOT1: inner_reg[0] <= pwdata[KNOT_W-1:0];
                REG_KNOT2: inner_reg[1] <= pwdata[KNOT_W-1:0];
                REG_KNOT3: inner_reg[2] <= pwdata[KNOT_W-1:0];
                REG_KNOT4: inner_reg[3] <= pwdata[KNOT_W-1:0];
                REG_KNOT5: inner_reg[4] <= pwdata[KNOT_W-1:0];
                default:   inner_reg[5] <= pwdata[KNOT_W-1:0];
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_LOWER: prdata = {16'd0, lower_reg};
            REG_UPPER: prdata = {16'd0, upper_reg};
            REG_KNOT1: prdata = {16'd0, inner_reg[0]};
            REG_KNOT2: prdata = {16'd0, inner_reg[1]};
            REG_KNOT3: prdata = {16'd0, inner_reg[2]};
            REG_KNOT4: prdata = {16'd0, inner_reg[3]};
            REG_KNOT5: prdata = {16'd0, inner_reg[4]};
            default:   prdata = {16'd0, inner_reg[5]};
        endcase
    end

    // Full knot vector with repeated boundary knots.
    always_comb begin
        for (int j = 0; j < NKNOT; j++) begin
            if (j < MORD) begin
                knots[j] = lower_reg;
            end else if (j < MORD + NUM_INNER) begin
                knots[j] = inner_reg[j - MORD];
            end else begin
                knots[j] = upper_reg;
            end
        end
    end

    // Interval search on the incoming sample; the last matching interval wins.
    always_comb begin
        jint_srch  = '0;
        found_srch = 1'b0;
        for (int j = 0; j < NSRCH; j++) begin
            if (knots[j] <= s_sample && s_sample < knots[j+1]) begin
                jint_srch  = IDX_W'(j);
                found_srch = 1'b1;
            end
        end
    end

    // Command broadcast to the chain.
    always_comb begin
        case (state_reg)
            ST_LOAD:  cmd.op = OP_LOAD;
            ST_MUL:   cmd.op = OP_MUL;
            ST_SUMI:  cmd.op = OP_SUMI;
            ST_SUM:   cmd.op = OP_SUM;
            ST_BIAS:  cmd.op = OP_BIAS;
            ST_DIV:   cmd.op = OP_DIV;
            ST_STORE: cmd.op = OP_STORE;
            default:  cmd.op = OP_NOP;
        endcase
        if (lvl_reg == 4'd1) begin
            cmd.phase = PH_BASE;
            cmd.lvl   = LVL_W'(1);
        end else if (int'(lvl_reg) <= MORD) begin
            cmd.phase = PH_REC;
            cmd.lvl   = lvl_reg[LVL_W-1:0];
        end else begin
            cmd.phase = PH_INT;
            cmd.lvl   = LVL_W'(MORD);
        end
        cmd.jint = jint_reg;
        cmd.save = (int'(lvl_reg) == ORDER);
    end

    // Chain of cells, one per knot interval.
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        logic [MV_W-1:0]  nb_mv;
        logic [ACC_W-1:0] nb_acc;
        if (g == NCELL - 1) begin : g_end
            assign nb_mv  = '0;
            assign nb_acc = '0;
        end else begin : g_mid
            assign nb_mv  = mv_arr[g+1];
            assign nb_acc = acc_arr[g+1];
        end
        sbe_cell #(
            .IDX   (g),
            .NKNOT (NKNOT),
            .MORD  (MORD)
        ) u_cell (
            .aclk   (aclk),
            .cmd    (cmd),
            .sample (x_reg),
            .knots  (knots),
            .nb_mv  (nb_mv),
            .nb_acc (nb_acc),
            .mv     (mv_arr[g]),
            .acc    (acc_arr[g]),
            .mo     (mo_arr[g]),
            .iv     (iv_arr[g])
        );
    end

    // Result word for the next basis index.
    always_comb begin
        b_sel  = (state_reg == ST_STORE) ? 4'd0 : b_reg + 4'd1;
        mo_sel = '0;
        iv_sel = '0;
        for (int c = 0; c < NCELL; c++) begin
            if (c == int'(b_sel) + 1) begin
                mo_sel = mo_arr[c];
                iv_sel = iv_arr[c];
            end
        end
        if (!found_reg) begin
            ival_sel = top_reg ? I_ONE : '0;
        end else if (int'(b_sel) + 1 + ORDER <= int'(jint_reg)) begin
            ival_sel = I_ONE;
        end else if (int'(b_sel) + 1 <= int'(jint_reg)) begin
            ival_sel = iv_sel;
        end else begin
            ival_sel = '0;
        end
    end

    // Sequencer and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            lvl_reg     <= 4'd1;
            cnt_reg     <= '0;
            b_reg       <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        x_reg     <= s_sample;
                        jint_reg  <= jint_srch;
                        found_reg <= found_srch;
                        top_reg   <= (s_sample >= upper_reg);
                        lvl_reg   <= 4'd1;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    cnt_reg   <= '0;
                    state_reg <= (lvl_reg == 4'd1) ? ST_DIV : ST_MUL;
                end
                ST_MUL: begin
                    if (int'(cnt_reg) == MUL_W - 1) begin
                        cnt_reg   <= '0;
                        state_reg <= (int'(lvl_reg) > MORD) ? ST_SUMI : ST_DIV;
                    end else begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_SUMI: begin
                    cnt_reg   <= '0;
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    if (int'(cnt_reg) == NCELL - 1) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_BIAS;
                    end else begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_BIAS: begin
                    cnt_reg   <= '0;
                    state_reg <= ST_STORE;
                end
                ST_DIV: begin
                    if (int'(cnt_reg) == ACC_W - 1) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_STORE;
                    end else begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_STORE: begin
                    if (int'(lvl_reg) > MORD) begin
                        b_reg       <= '0;
                        m_valid_reg <= 1'b1;
                        m_index_reg <= b_sel;
                        m_mval_reg  <= mo_sel;
                        m_ival_reg  <= ival_sel;
                        m_last_reg  <= (NBASIS == 1);
                        state_reg   <= ST_EMIT;
                    end else begin
                        lvl_reg   <= lvl_reg + 4'd1;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_EMIT: begin
                    if (m_ready) begin
                        if (m_last_reg) begin
                            m_valid_reg <= 1'b0;
                            state_reg   <= ST_IDLE;
                        end else begin
                            b_reg       <= b_sel;
                            m_index_reg <= b_sel;
                            m_mval_reg  <= mo_sel;
                            m_ival_reg  <= ival_sel;
                            m_last_reg  <= (int'(b_sel) == NBASIS - 1);
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_basis_index = m_index_reg;
    assign m_m_value     = m_mval_reg;
    assign m_i_value     = m_ival_reg;
    assign m_last        = m_last_reg;

endmodule
